### hdl/cbvd_pkg.sv
// Shared types and constants for the crease brush vertex displacement block.
// Used by every module under hdl; no dependencies of its own.
package cbvd_pkg;

    localparam int COORD_W    = 32;
    localparam int PUSH_W     = 16;
    localparam int RAD_W      = 31;
    localparam int STR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int QUO_W      = 31;

    localparam logic [PUSH_W-1:0] RST_PUSH_Z   = 16'd16384;
    localparam logic [RAD_W-1:0]  RST_RADIUS   = 31'd65536;
    localparam logic [STR_W-1:0]  RST_STRENGTH = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_PUSH_X   = 3'd3,
        CFG_PUSH_Y   = 3'd4,
        CFG_PUSH_Z   = 3'd5,
        CFG_RADIUS   = 3'd6,
        CFG_STRENGTH = 3'd7
    } t_cfg_idx;

    // Brush settings; the user must keep them stable while items are in flight, as no logic enforces it.
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [PUSH_W-1:0]  px;
        logic [PUSH_W-1:0]  py;
        logic [PUSH_W-1:0]  pz;
        logic [RAD_W-1:0]   radius;
        logic [STR_W-1:0]   strength;
    } t_cfg;

    // Per-vertex data that rides along the pipeline.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               in_brush;
    } t_side;

endpackage

### hdl/cbvd_front.sv
// Front end: distance to the brush centre, squared length and inside test.
// Three register stages; depends on cbvd_pkg.
module cbvd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cbvd_pkg::COORD_W-1:0]  i_vx,
    input  logic [cbvd_pkg::COORD_W-1:0]  i_vy,
    input  logic [cbvd_pkg::COORD_W-1:0]  i_vz,
    input  cbvd_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output logic [cbvd_pkg::SUM_W-1:0]    o_sum,
    output cbvd_pkg::t_side               o_side
);
    logic [31:0]        w_v   [3];
    logic [31:0]        w_c   [3];
    logic signed [32:0] w_d   [3];
    logic [32:0]        w_mag [3];
    logic               w_far;
    logic [63:0]        w_sum;

    logic               r1_vld, r2_vld, r3_vld;
    cbvd_pkg::t_side    r1_side, r2_side, r3_side;
    logic [30:0]        r1_mag [3];
    logic [61:0]        r2_sq  [3];
    logic [61:0]        r2_rr;
    logic [63:0]        r3_sum;

    assign w_v[0] = i_vx;
    assign w_v[1] = i_vy;
    assign w_v[2] = i_vz;
    assign w_c[0] = i_cfg.cx;
    assign w_c[1] = i_cfg.cy;
    assign w_c[2] = i_cfg.cz;

    always_comb begin
        w_far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = $signed({w_c[i][31], w_c[i]}) - $signed({w_v[i][31], w_v[i]});
            w_mag[i] = w_d[i][32] ? 33'(-w_d[i]) : 33'(w_d[i]);
            if (w_mag[i] > {2'b00, i_cfg.radius}) begin
                w_far = 1'b1;
            end
        end
    end

    assign w_sum = 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side.x        <= i_vx;
            r1_side.y        <= i_vy;
            r1_side.z        <= i_vz;
            r1_side.in_brush <= !w_far && (i_cfg.radius != '0);
            for (int i = 0; i < 3; i++) begin
                r1_mag[i] <= w_mag[i][30:0];
                r2_sq[i]  <= r1_mag[i] * r1_mag[i];
            end
            r2_rr   <= i_cfg.radius * i_cfg.radius;
            r2_side <= r1_side;
            r3_side.x        <= r2_side.x;
            r3_side.y        <= r2_side.y;
            r3_side.z        <= r2_side.z;
            r3_side.in_brush <= r2_side.in_brush && (w_sum <= 64'(r2_rr));
            r3_sum  <= w_sum;
        end
    end

    assign o_valid = r3_vld;
    assign o_sum   = r3_sum;
    assign o_side  = r3_side;

endmodule

### hdl/cbvd_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on cbvd_pkg.
module cbvd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cbvd_pkg::SUM_W-1:0]    i_x,
    input  cbvd_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [cbvd_pkg::ROOT_W-1:0]   o_root,
    output cbvd_pkg::t_side               o_side
);
    localparam int N  = cbvd_pkg::ROOT_W;
    localparam int XW = cbvd_pkg::SUM_W;
    localparam int RW = N + 3;

    logic [XW-1:0]   r_x    [N];
    logic [RW-1:0]   r_rem  [N];
    logic [N-1:0]    r_root [N];
    cbvd_pkg::t_side r_side [N];
    logic            r_vld  [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic [XW-1:0]   w_x;
        logic [RW-1:0]   w_rem;
        logic [N-1:0]    w_root;
        cbvd_pkg::t_side w_sd;
        logic            w_v;
        logic [RW-1:0]   w_cat;
        logic [RW-1:0]   w_trial;

        if (k == 0) begin : g_first
            assign w_x    = i_x;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_sd   = i_side;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_sd   = r_side[k-1];
            assign w_v    = r_vld[k-1];
        end

        // Bring down the next two bits and try root*4+1 against the remainder.
        assign w_cat   = {w_rem[RW-3:0], w_x[XW-1:XW-2]};
        assign w_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[XW-3:0], 2'b00};
                r_side[k] <= w_sd;
                if (w_cat >= w_trial) begin
                    r_rem[k]  <= w_cat - w_trial;
                    r_root[k] <= {w_root[N-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cat;
                    r_root[k] <= {w_root[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

### hdl/cbvd_div.sv
// Pipelined restoring divider for (radius - length) * 2^30 / radius,
// one quotient bit per stage after a subtract stage. Depends on cbvd_pkg.
module cbvd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cbvd_pkg::ROOT_W-1:0]   i_len,
    input  cbvd_pkg::t_side               i_side,
    input  logic [cbvd_pkg::RAD_W-1:0]    i_radius,
    output logic                          o_valid,
    output logic [cbvd_pkg::QUO_W-1:0]    o_quo,
    output cbvd_pkg::t_side               o_side
);
    localparam int N  = cbvd_pkg::QUO_W;
    localparam int DW = cbvd_pkg::RAD_W;

    logic            r_a_vld;
    logic [DW-1:0]   r_a;
    cbvd_pkg::t_side r_a_side;

    logic [DW-1:0]   r_rem  [N];
    logic [N-1:0]    r_q    [N];
    cbvd_pkg::t_side r_side [N];
    logic            r_vld  [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    // Inside the brush the length never exceeds the radius.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_radius - i_len[DW-1:0];
            r_a_side <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic [DW:0]     w_cand;
        logic [N-1:0]    w_q;
        cbvd_pkg::t_side w_sd;
        logic            w_v;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_cand = {1'b0, r_a};
            assign w_q    = '0;
            assign w_sd   = r_a_side;
            assign w_v    = r_a_vld;
        end else begin : g_next
            assign w_cand = {r_rem[k-1], 1'b0};
            assign w_q    = r_q[k-1];
            assign w_sd   = r_side[k-1];
            assign w_v    = r_vld[k-1];
        end

        assign w_ge = w_cand >= {1'b0, i_radius};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_sd;
                r_q[k]    <= {w_q[N-2:0], w_ge};
                r_rem[k]  <= w_ge ? DW'(w_cand - {1'b0, i_radius}) : w_cand[DW-1:0];
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_q[N-1];
    assign o_side  = r_side[N-1];

endmodule

### hdl/cbvd_back.sv
// Back end: falloff weights from 1 - d, displacement products, rounding and
// saturating sums. Eleven register stages; depends on cbvd_pkg.
module cbvd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cbvd_pkg::QUO_W-1:0]    i_u,
    input  cbvd_pkg::t_side               i_side,
    input  cbvd_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output logic [cbvd_pkg::COORD_W-1:0]  o_new_x,
    output logic [cbvd_pkg::COORD_W-1:0]  o_new_y,
    output logic [cbvd_pkg::COORD_W-1:0]  o_new_z,
    output logic                          o_moved
);
    localparam int NS = 11;

    logic            r_vld [NS];
    cbvd_pkg::t_side r_sd  [NS-1];

    logic [61:0] r1_p;
    logic [30:0] r2_t;
    logic [46:0] r3_ts;
    logic [61:0] r3_t2;
    logic [31:0] r4_h, r5_h, r6_h, r7_h, r8_h;
    logic [30:0] r4_tt;
    logic [61:0] r5_tr;
    logic [30:0] r6_vr;
    logic [46:0] r7_vs;
    logic [30:0] r8_vf;
    logic [30:0] r8_dm [3];
    logic        r8_dn [3];
    logic        r9_dn [3];
    logic [62:0] r9_pd [3];
    logic [46:0] r9_pp [3];
    logic [35:0] r10_td [3];
    logic [35:0] r10_tp [3];
    logic [31:0] r_new [3];
    logic        r_moved;

    logic [61:0]        w_t_rnd, w_tt_rnd, w_vr_rnd;
    logic [46:0]        w_h_rnd, w_vf_rnd;
    logic [31:0]        w_v   [3];
    logic [31:0]        w_c   [3];
    logic [15:0]        w_p   [3];
    logic [15:0]        w_pm  [3];
    logic signed [32:0] w_d   [3];
    logic [63:0]        w_rd  [3];
    logic [47:0]        w_rp  [3];
    logic [33:0]        w_rdq [3];
    logic [33:0]        w_rpq [3];
    logic [31:0]        w_vo  [3];
    logic signed [35:0] w_sum [3];

    assign w_t_rnd  = r1_p  + (62'd1 << 29);
    assign w_h_rnd  = r3_ts + (47'd1 << 14);
    assign w_tt_rnd = r3_t2 + (62'd1 << 29);
    assign w_vr_rnd = r5_tr + (62'd1 << 29);
    assign w_vf_rnd = r7_vs + (47'd1 << 15);

    assign w_v[0]  = r_sd[6].x;
    assign w_v[1]  = r_sd[6].y;
    assign w_v[2]  = r_sd[6].z;
    assign w_vo[0] = r_sd[9].x;
    assign w_vo[1] = r_sd[9].y;
    assign w_vo[2] = r_sd[9].z;
    assign w_c[0]  = i_cfg.cx;
    assign w_c[1]  = i_cfg.cy;
    assign w_c[2]  = i_cfg.cz;
    assign w_p[0]  = i_cfg.px;
    assign w_p[1]  = i_cfg.py;
    assign w_p[2]  = i_cfg.pz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = $signed({w_c[i][31], w_c[i]}) - $signed({w_v[i][31], w_v[i]});
            w_pm[i]  = w_p[i][15] ? 16'(-w_p[i]) : w_p[i];
            w_rd[i]  = 64'(r9_pd[i]) + (64'd1 << 29);
            w_rp[i]  = 48'(r9_pp[i]) + (48'd1 << 13);
            w_rdq[i] = w_rd[i][63:30];
            w_rpq[i] = w_rp[i][47:14];
            w_sum[i] = $signed({{4{w_vo[i][31]}}, w_vo[i]}) + $signed(r10_td[i])
                     + $signed(r10_tp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 1; k < NS - 1; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r1_p  <= i_u * i_u;
            r2_t  <= w_t_rnd[60:30];
            r3_ts <= r2_t * i_cfg.strength;
            r3_t2 <= r2_t * r2_t;
            r4_h  <= w_h_rnd[46:15];
            r4_tt <= w_tt_rnd[60:30];
            r5_tr <= r4_tt * i_cfg.radius;
            r5_h  <= r4_h;
            r6_vr <= w_vr_rnd[60:30];
            r6_h  <= r5_h;
            r7_vs <= r6_vr * i_cfg.strength;
            r7_h  <= r6_h;
            r8_vf <= w_vf_rnd[46:16];
            r8_h  <= r7_h;
            for (int i = 0; i < 3; i++) begin
                // Inside the brush each delta magnitude fits in the radius width.
                r8_dm[i]  <= w_d[i][32] ? 31'(-w_d[i]) : w_d[i][30:0];
                r8_dn[i]  <= w_d[i][32];
                r9_pd[i]  <= r8_dm[i] * r8_h;
                r9_pp[i]  <= w_pm[i] * r8_vf;
                r9_dn[i]  <= r8_dn[i];
                r10_td[i] <= r9_dn[i] ? 36'd0 - {2'b00, w_rdq[i]} : {2'b00, w_rdq[i]};
                r10_tp[i] <= w_p[i][15] ? 36'd0 - {2'b00, w_rpq[i]} : {2'b00, w_rpq[i]};
                if (!r_sd[9].in_brush) begin
                    r_new[i] <= w_vo[i];
                end else if (w_sum[i] > 36'sd2147483647) begin
                    r_new[i] <= 32'h7FFF_FFFF;
                end else if (w_sum[i] < -36'sd2147483648) begin
                    r_new[i] <= 32'h8000_0000;
                end else begin
                    r_new[i] <= w_sum[i][31:0];
                end
            end
            r_moved <= r_sd[9].in_brush;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_new_x = r_new[0];
    assign o_new_y = r_new[1];
    assign o_new_z = r_new[2];
    assign o_moved = r_moved;

endmodule

### hdl/crease_brush_vertex_displace_unit.sv
// Crease brush vertex displacement, top level: brush registers and the
// pipeline of front end, square root, divider and back end. Uses cbvd_pkg.
//
// Usage: vertices enter on i_valid / o_stall with i_vert_x/y/z, one beat
// per vertex; results leave on o_valid / i_stall with o_new_x/y/z and
// o_moved, one beat per vertex, in order. Brush settings are written on
// i_cfg_valid / o_cfg_ready (always ready) by index; the user must write
// them only while the pipeline is empty, as the block does not enforce it.
// The pipeline has 3 front stages, 32 square root stages, 32 divider
// stages (one subtract, one per quotient bit) and 11 back end stages.
// Throughput is one vertex per cycle while the receiver does not stall;
// the bit-serial root and divider set the depth, not the rate.
// When the receiver stalls with a result waiting, every stage holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads centre 0, push (0, 0, 1.0),
// radius 1.0 and intensity 0.5.
module crease_brush_vertex_displace_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cbvd_pkg::COORD_W-1:0]    i_vert_x,
    input  logic [cbvd_pkg::COORD_W-1:0]    i_vert_y,
    input  logic [cbvd_pkg::COORD_W-1:0]    i_vert_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [cbvd_pkg::COORD_W-1:0]    o_new_x,
    output logic [cbvd_pkg::COORD_W-1:0]    o_new_y,
    output logic [cbvd_pkg::COORD_W-1:0]    o_new_z,
    output logic                            o_moved,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbvd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbvd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    cbvd_pkg::t_cfg  r_cfg;
    logic            w_en;

    logic                          w_f_vld, w_s_vld, w_d_vld;
    logic [cbvd_pkg::SUM_W-1:0]    w_f_sum;
    logic [cbvd_pkg::ROOT_W-1:0]   w_s_root;
    logic [cbvd_pkg::QUO_W-1:0]    w_d_quo;
    cbvd_pkg::t_side               w_f_side, w_s_side, w_d_side;

    // The whole pipeline moves together unless a finished beat is held.
    assign w_en        = !o_valid || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cx       <= '0;
            r_cfg.cy       <= '0;
            r_cfg.cz       <= '0;
            r_cfg.px       <= '0;
            r_cfg.py       <= '0;
            r_cfg.pz       <= cbvd_pkg::RST_PUSH_Z;
            r_cfg.radius   <= cbvd_pkg::RST_RADIUS;
            r_cfg.strength <= cbvd_pkg::RST_STRENGTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cbvd_pkg::t_cfg_idx'(i_cfg_index))
                cbvd_pkg::CFG_CENTER_X: r_cfg.cx       <= i_cfg_data;
                cbvd_pkg::CFG_CENTER_Y: r_cfg.cy       <= i_cfg_data;
                cbvd_pkg::CFG_CENTER_Z: r_cfg.cz       <= i_cfg_data;
                cbvd_pkg::CFG_PUSH_X:   r_cfg.px       <= i_cfg_data[15:0];
                cbvd_pkg::CFG_PUSH_Y:   r_cfg.py       <= i_cfg_data[15:0];
                cbvd_pkg::CFG_PUSH_Z:   r_cfg.pz       <= i_cfg_data[15:0];
                cbvd_pkg::CFG_RADIUS:   r_cfg.radius   <= i_cfg_data[30:0];
                cbvd_pkg::CFG_STRENGTH: r_cfg.strength <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cbvd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vx    (i_vert_x),
        .i_vy    (i_vert_y),
        .i_vz    (i_vert_z),
        .i_cfg   (r_cfg),
        .o_valid (w_f_vld),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    cbvd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_x     (w_f_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    cbvd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_s_vld),
        .i_len    (w_s_root),
        .i_side   (w_s_side),
        .i_radius (r_cfg.radius),
        .o_valid  (w_d_vld),
        .o_quo    (w_d_quo),
        .o_side   (w_d_side)
    );

    cbvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_vld),
        .i_u     (w_d_quo),
        .i_side  (w_d_side),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_new_x (o_new_x),
        .o_new_y (o_new_y),
        .o_new_z (o_new_z),
        .o_moved (o_moved)
    );

endmodule

### hdl/cbvd_checker.sv
// Port-level checks for the crease brush vertex displacement block, bound
// to the top level. Uses cbvd_pkg for widths.
module cbvd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [cbvd_pkg::COORD_W-1:0]    i_vert_x,
    input logic [cbvd_pkg::COORD_W-1:0]    i_vert_y,
    input logic [cbvd_pkg::COORD_W-1:0]    i_vert_z,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [cbvd_pkg::COORD_W-1:0]    o_new_x,
    input logic [cbvd_pkg::COORD_W-1:0]    o_new_y,
    input logic [cbvd_pkg::COORD_W-1:0]    o_new_z,
    input logic                            o_moved,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [cbvd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [cbvd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    // The input side is held back only by a result beat that is itself held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result beat");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_new_x) && $stable(o_new_y)
                                  && $stable(o_new_z) && $stable(o_moved)))
        else $error("result payload changed while stalled");

endmodule

bind crease_brush_vertex_displace_unit cbvd_checker u_cbvd_checker (.*);
